### design/lqpc_pkg.sv
// Shared constants, register and mode codes, and the divider request type
// for the lane queue polygon counter. No dependencies.
`default_nettype none

package lqpc_pkg;

    localparam int MAX_LANES_DEF    = 8;
    localparam int MAX_VERTICES_DEF = 8;
    localparam int COORD_BITS_DEF   = 12;

    // at most this many lane results per report
    localparam int MAX_OUT = 8;

    localparam int CFG_DATA_BITS  = 15;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_STOPPED_SPEED = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LANE_CAPACITY = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LANES_IN_USE  = 2'd2;

    localparam logic [14:0] STOPPED_SPEED_RST = 15'd256;
    localparam logic [7:0]  LANE_CAPACITY_RST = 8'd15;
    localparam logic [3:0]  LANES_IN_USE_RST  = 4'd1;

    localparam logic [1:0] MODE_VERTEX = 2'd0;
    localparam logic [1:0] MODE_OBJECT = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;

    localparam int DIV_BITS     = 28;
    localparam int DIV_DEN_BITS = 8;

    typedef struct packed {
        logic                    start;
        logic [DIV_BITS-1:0]     num;
        logic [DIV_DEN_BITS-1:0] den;
    } div_req_t;

endpackage

`default_nettype wire

### design/lane_queue_polygon_counter.sv
// Lane queue polygon counter. An object word is tested, for each lane in use,
// against that lane's polygon, skipping a lane whose polygon is empty: one
// vertex memory read and one edge compare per edge. A report word runs two
// serial divisions of 28 steps each per lane in use on the shared divider (only
// the first for a lane with no stopped vehicle), and an output stall holds it.
// The next word is taken once the previous one has finished; a finished result
// waits in the output register without holding the input. No clearing pass
// after reset.
`default_nettype none

module lane_queue_polygon_counter #(
    parameter int MAX_LANES    = lqpc_pkg::MAX_LANES_DEF,
    parameter int MAX_VERTICES = lqpc_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = lqpc_pkg::COORD_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [1:0]                            mode,
    input  wire logic [2:0]                            lane_sel,
    input  wire logic [2:0]                            vertex_sel,
    input  wire logic [3:0]                            vertex_total,
    input  wire logic [COORD_BITS-1:0]                 coord_x,
    input  wire logic [COORD_BITS-1:0]                 coord_y,
    input  wire logic [COORD_BITS-1:0]                 box_width,
    input  wire logic [COORD_BITS-1:0]                 box_height,
    input  wire logic signed [15:0]                    speed_x,
    input  wire logic signed [15:0]                    speed_y,
    input  wire logic [19:0]                           age_ms,

    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [2:0]                                 lane_index,
    output logic [7:0]                                 vehicle_count,
    output logic [8:0]                                 density_q8,
    output logic [19:0]                                avg_wait_ms,
    output logic [10:0]                                running_total,
    output logic [8:0]                                 max_density_q8,
    output logic [19:0]                                max_wait_ms,
    output logic                                       last,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [lqpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [lqpc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int DEPTH      = MAX_LANES * MAX_VERTICES;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LANE_BITS  = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int LANE_CNT_BITS = $clog2(MAX_LANES + 1);
    localparam int VTX_BITS   = $clog2(MAX_VERTICES);
    localparam int VCNT_BITS  = $clog2(MAX_VERTICES + 1);
    localparam int LANE_LIMIT = (MAX_LANES < lqpc_pkg::MAX_OUT) ? MAX_LANES
                                                                : lqpc_pkg::MAX_OUT;
    localparam int SW         = COORD_BITS + 4;
    localparam int PW         = 2 * SW;
    localparam int NB         = lqpc_pkg::DIV_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_STOP,
        ST_LANE,
        ST_PREV,
        ST_FETCH,
        ST_CMP,
        ST_UPDATE,
        ST_REP_LANE,
        ST_REP_DENS,
        ST_REP_WAIT,
        ST_REP_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [14:0] stopped_speed_reg;
    logic [7:0]  lane_capacity_reg;
    logic [3:0]  lanes_in_use_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_speed_reg <= lqpc_pkg::STOPPED_SPEED_RST;
            lane_capacity_reg <= lqpc_pkg::LANE_CAPACITY_RST;
            lanes_in_use_reg  <= lqpc_pkg::LANES_IN_USE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lqpc_pkg::REG_STOPPED_SPEED: stopped_speed_reg <= cfg_data[14:0];
                lqpc_pkg::REG_LANE_CAPACITY: lane_capacity_reg <= cfg_data[7:0];
                lqpc_pkg::REG_LANES_IN_USE:  lanes_in_use_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic [LANE_CNT_BITS-1:0] nact;
    logic [7:0]               cap;

    always_comb
    begin
        if (lanes_in_use_reg == 4'd0)
        begin
            nact = LANE_CNT_BITS'(1);
        end
        else if (int'(lanes_in_use_reg) > LANE_LIMIT)
        begin
            nact = LANE_CNT_BITS'(LANE_LIMIT);
        end
        else
        begin
            nact = LANE_CNT_BITS'(lanes_in_use_reg);
        end
    end

    assign cap = (lane_capacity_reg == 8'd0) ? 8'd1 : lane_capacity_reg;

    // per-lane state
    logic [VCNT_BITS-1:0] psize    [MAX_LANES];
    logic [7:0]           veh_cnt  [MAX_LANES];
    logic [7:0]           stop_cnt [MAX_LANES];
    logic [27:0]          wait_sum [MAX_LANES];

    logic                     accept;
    logic [LANE_CNT_BITS-1:0] lane_reg;
    logic [LANE_BITS-1:0]     lane_idx;
    logic [VTX_BITS-1:0]      idx_reg;
    logic [VCNT_BITS-1:0]     lane_size;
    logic                     vtx_ok;
    logic [ADDR_BITS-1:0]     wr_addr;
    logic [VCNT_BITS-1:0]     tot_sat;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign lane_idx  = lane_reg[LANE_BITS-1:0];
    assign lane_size = psize[lane_idx];
    assign vtx_ok    = (int'(lane_sel) < MAX_LANES) && (int'(vertex_sel) < MAX_VERTICES);
    assign wr_addr   = ADDR_BITS'(int'(lane_sel) * MAX_VERTICES + int'(vertex_sel));
    assign tot_sat   = (int'(vertex_total) > MAX_VERTICES) ? VCNT_BITS'(MAX_VERTICES)
                                                           : VCNT_BITS'(vertex_total);

    // vertex memory
    logic                       rd_en;
    logic [VTX_BITS-1:0]        rd_vtx;
    logic [ADDR_BITS-1:0]       rd_addr;
    logic [2*COORD_BITS-1:0]    rd_data;
    logic                       edge_more;

    assign edge_more = (VCNT_BITS'(idx_reg) + 1'b1) != lane_size;

    always_comb
    begin
        rd_en  = 1'b0;
        rd_vtx = '0;
        case (state_reg)
            ST_LANE:
            begin
                rd_en  = (lane_reg != nact) && (lane_size != '0);
                rd_vtx = VTX_BITS'(lane_size - 1'b1);
            end
            ST_PREV:
            begin
                rd_en = 1'b1;
            end
            ST_CMP:
            begin
                rd_en  = edge_more;
                rd_vtx = idx_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign rd_addr = ADDR_BITS'(int'(lane_idx) * MAX_VERTICES + int'(rd_vtx));

    lqpc_vertex_ram #(
        .DEPTH     (DEPTH),
        .WIDTH     (2 * COORD_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_vertex_ram (
        .clk     (clk),
        .wr_en   (accept && (mode == lqpc_pkg::MODE_VERTEX) && vtx_ok),
        .wr_addr (wr_addr),
        .wr_data ({coord_x, coord_y}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // edge test datapath
    logic signed [SW-1:0] px_reg, py_reg;
    logic signed [SW-1:0] prev_x_reg, prev_y_reg;
    logic signed [SW-1:0] cur_x, cur_y;
    logic signed [SW-1:0] cur_x_reg, cur_y_reg;
    logic signed [SW-1:0] d_edge;
    logic signed [PW-1:0] lhs_next, rhs_next, lhs_reg, rhs_reg;
    logic                 span_next, span_reg, dpos_reg;
    logic                 edge_cross;
    logic                 in_reg, in_next;

    assign cur_x    = $signed(SW'({rd_data[2*COORD_BITS-1:COORD_BITS], 1'b0}));
    assign cur_y    = $signed(SW'({rd_data[COORD_BITS-1:0], 1'b0}));
    assign d_edge   = prev_y_reg - cur_y;
    assign span_next = (cur_y > py_reg) != (prev_y_reg > py_reg);
    assign lhs_next = (px_reg - cur_x) * d_edge;
    assign rhs_next = (prev_x_reg - cur_x) * (py_reg - cur_y);
    assign edge_cross = dpos_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);
    assign in_next  = in_reg ^ (span_reg && edge_cross);

    // speed test
    logic signed [15:0] vx_reg, vy_reg;
    logic [31:0]        sqx_reg, sqy_reg;
    logic [29:0]        thr2_reg;
    logic               stopped_reg;
    logic [19:0]        age_reg;

    // report datapath
    lqpc_pkg::div_req_t div_req;
    logic               div_done;
    logic [NB-1:0]      div_q;
    logic [8:0]         dens_reg;
    logic [19:0]        avg_reg;
    logic [10:0]        total_reg;
    logic [8:0]         maxd_reg;
    logic [19:0]        maxw_reg;
    logic               out_valid_reg;
    logic               out_free;
    logic               out_load;
    logic [10:0]        total_next;
    logic [8:0]         maxd_next;
    logic [19:0]        maxw_next;

    assign out_free   = !out_valid_reg || !out_stall;
    assign out_load   = (state_reg == ST_REP_OUT) && out_free;
    assign total_next = total_reg + 11'(veh_cnt[lane_idx]);
    assign maxd_next  = (dens_reg > maxd_reg) ? dens_reg : maxd_reg;
    assign maxw_next  = (avg_reg > maxw_reg) ? avg_reg : maxw_reg;

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = NB'({veh_cnt[lane_idx], 8'd0});
        div_req.den   = cap;
        if (state_reg == ST_REP_LANE)
        begin
            div_req.start = (lane_reg != nact);
        end
        else if ((state_reg == ST_REP_DENS) && div_done)
        begin
            div_req.start = (stop_cnt[lane_idx] != 8'd0);
            div_req.num   = NB'(wait_sum[lane_idx]);
            div_req.den   = stop_cnt[lane_idx];
        end
    end

    lqpc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lane_reg      <= '0;
            idx_reg       <= '0;
            in_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (mode == lqpc_pkg::MODE_OBJECT))
                    begin
                        state_reg <= ST_SQ;
                    end
                    else if (accept && (mode == lqpc_pkg::MODE_REPORT))
                    begin
                        lane_reg  <= '0;
                        state_reg <= ST_REP_LANE;
                    end
                end
                ST_SQ:
                begin
                    state_reg <= ST_STOP;
                end
                ST_STOP:
                begin
                    lane_reg  <= '0;
                    state_reg <= ST_LANE;
                end
                ST_LANE:
                begin
                    if (lane_reg == nact)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (lane_size == '0)
                    begin
                        lane_reg <= lane_reg + 1'b1;
                    end
                    else
                    begin
                        in_reg    <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= ST_PREV;
                    end
                end
                ST_PREV:
                begin
                    state_reg <= ST_FETCH;
                end
                ST_FETCH:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    in_reg <= in_next;
                    if (edge_more)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_FETCH;
                    end
                    else
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    lane_reg  <= lane_reg + 1'b1;
                    state_reg <= ST_LANE;
                end
                ST_REP_LANE:
                begin
                    state_reg <= (lane_reg == nact) ? ST_IDLE : ST_REP_DENS;
                end
                ST_REP_DENS:
                begin
                    if (div_done)
                    begin
                        state_reg <= (stop_cnt[lane_idx] != 8'd0) ? ST_REP_WAIT
                                                                  : ST_REP_OUT;
                    end
                end
                ST_REP_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_REP_OUT;
                    end
                end
                ST_REP_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        lane_reg      <= lane_reg + 1'b1;
                        state_reg     <= ST_REP_LANE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && (mode == lqpc_pkg::MODE_OBJECT))
        begin
            px_reg  <= $signed(SW'({coord_x, 1'b0}) + SW'(box_width));
            py_reg  <= $signed(SW'({coord_y, 1'b0}) + SW'(box_height));
            vx_reg  <= speed_x;
            vy_reg  <= speed_y;
            age_reg <= age_ms;
        end
        if (accept && (mode == lqpc_pkg::MODE_REPORT))
        begin
            total_reg <= '0;
            maxd_reg  <= '0;
            maxw_reg  <= '0;
        end
        if (state_reg == ST_SQ)
        begin
            sqx_reg  <= 32'(vx_reg) * 32'(vx_reg);
            sqy_reg  <= 32'(vy_reg) * 32'(vy_reg);
            thr2_reg <= 30'(stopped_speed_reg) * 30'(stopped_speed_reg);
        end
        if (state_reg == ST_STOP)
        begin
            stopped_reg <= (33'(sqx_reg) + 33'(sqy_reg)) < 33'(thr2_reg);
        end
        if (state_reg == ST_PREV)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        if (state_reg == ST_FETCH)
        begin
            cur_x_reg <= cur_x;
            cur_y_reg <= cur_y;
            lhs_reg   <= lhs_next;
            rhs_reg   <= rhs_next;
            span_reg  <= span_next;
            dpos_reg  <= (d_edge > 0);
        end
        if (state_reg == ST_CMP)
        begin
            // this vertex is the far end of the next edge
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if ((state_reg == ST_REP_DENS) && div_done)
        begin
            dens_reg <= (div_q > NB'(256)) ? 9'd256 : div_q[8:0];
            avg_reg  <= '0;
        end
        if ((state_reg == ST_REP_WAIT) && div_done)
        begin
            avg_reg <= div_q[19:0];
        end
        if (out_load)
        begin
            lane_index     <= 3'(lane_reg);
            vehicle_count  <= veh_cnt[lane_idx];
            density_q8     <= dens_reg;
            avg_wait_ms    <= avg_reg;
            running_total  <= total_next;
            max_density_q8 <= maxd_next;
            max_wait_ms    <= maxw_next;
            last           <= (lane_reg + 1'b1) == nact;
            total_reg      <= total_next;
            maxd_reg       <= maxd_next;
            maxw_reg       <= maxw_next;
        end
    end

    assign out_valid = out_valid_reg;

    // lane accumulators and polygon sizes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LANES; i++)
            begin
                psize[i]    <= '0;
                veh_cnt[i]  <= '0;
                stop_cnt[i] <= '0;
                wait_sum[i] <= '0;
            end
        end
        else
        begin
            if (accept && (mode == lqpc_pkg::MODE_VERTEX) && vtx_ok)
            begin
                psize[LANE_BITS'(lane_sel)] <= tot_sat;
            end
            if ((state_reg == ST_UPDATE) && in_reg)
            begin
                if (veh_cnt[lane_idx] != 8'd255)
                begin
                    veh_cnt[lane_idx] <= veh_cnt[lane_idx] + 1'b1;
                end
                if (stopped_reg && (stop_cnt[lane_idx] != 8'd255))
                begin
                    stop_cnt[lane_idx] <= stop_cnt[lane_idx] + 1'b1;
                    wait_sum[lane_idx] <= wait_sum[lane_idx] + 28'(age_reg);
                end
            end
            if ((state_reg == ST_REP_LANE) && (lane_reg == nact))
            begin
                // drop every lane's figures once the report is out
                for (int i = 0; i < MAX_LANES; i++)
                begin
                    veh_cnt[i]  <= '0;
                    stop_cnt[i] <= '0;
                    wait_sum[i] <= '0;
                end
            end
        end
    end

    a_div_done_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_REP_DENS) || (state_reg == ST_REP_WAIT))
        else $error("divider finished outside a report");

    a_lane_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LANE) || (state_reg == ST_REP_LANE)) |-> (lane_reg <= nact))
        else $error("lane counter ran past the lanes in use");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (VCNT_BITS'(idx_reg) < lane_size))
        else $error("edge index beyond polygon size");

    a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && ((lane_reg + 1'b1) == nact)) |=> (state_reg == ST_REP_LANE)
            && (lane_reg == nact))
        else $error("final lane result did not close the report");

endmodule

`default_nettype wire

### design/lqpc_vertex_ram.sv
// Polygon vertex store: one write port, one read port with registered data.
// Self-contained; the entries hold packed x and y corner coordinates.
`default_nettype none

module lqpc_vertex_ram #(
    parameter int DEPTH     = 64,
    parameter int WIDTH     = 24,
    parameter int ADDR_BITS = 6
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/lqpc_divider.sv
// Restoring divider, one quotient bit per cycle, for density and mean wait.
// Depends on lqpc_pkg for the request type and widths.
`default_nettype none

module lqpc_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lqpc_pkg::div_req_t         req,
    output logic                            done,
    output logic [lqpc_pkg::DIV_BITS-1:0]   quotient
);

    localparam int NB = lqpc_pkg::DIV_BITS;
    localparam int DB = lqpc_pkg::DIV_DEN_BITS;
    localparam int CB = $clog2(NB);

    logic          busy_reg;
    logic          done_reg;
    logic [CB-1:0] cnt_reg;
    logic [NB-1:0] num_reg;
    logic [DB-1:0] rem_reg;
    logic [DB-1:0] den_reg;
    logic [DB:0]   trial;
    logic          qbit;

    assign trial = {rem_reg, num_reg[NB-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CB'(NB - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, keep the quotient bit
            num_reg <= {num_reg[NB-2:0], qbit};
            rem_reg <= qbit ? DB'(trial - {1'b0, den_reg}) : trial[DB-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire
